[rtl/llt_pkg.sv]
// ----------------------------------------------------------------------------
// llt_pkg
// shared types, codes and default sizes for the lease lock table
// ----------------------------------------------------------------------------
package llt_pkg;

    localparam int DEF_BUS_COUNT = 4;
    localparam int DEF_ENTRIES   = 256;

    localparam int BUS_W  = 2;
    localparam int ADDR_W = 8;
    localparam int SESS_W = 16;
    localparam int LEASE_W = 16;
    localparam int CNT_W  = 11;

    typedef enum logic [2:0] {
        FN_ACTIVATE   = 3'd0,
        FN_DEACTIVATE = 3'd1,
        FN_LOCK       = 3'd2,
        FN_UNLOCK     = 3'd3,
        FN_GET_OWNER  = 3'd4,
        FN_TICK       = 3'd5,
        FN_RELEASE    = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_WRONG  = 2'd1,
        ST_LOCKED = 2'd2,
        ST_NODATA = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_WALK
    } state_t;

    typedef struct packed {
        logic               active;
        logic [SESS_W-1:0]  owner;
        logic [LEASE_W-1:0] lease;
    } entry_t;

    typedef struct packed {
        func_t              func;
        logic [BUS_W-1:0]   bus;
        logic [ADDR_W-1:0]  address;
        logic [SESS_W-1:0]  session;
        logic [LEASE_W-1:0] lease;
        logic               valid;
    } cmd_t;

    typedef struct packed {
        logic [BUS_W-1:0]  bus_last;
        logic [ADDR_W-1:0] addr_last;
    } limit_t;

    typedef struct packed {
        entry_t            entry;
        logic              wr;
        logic              rel;
        status_t           status;
        logic [SESS_W-1:0] owner;
    } unit_res_t;

endpackage

[rtl/lease_lock_table.sv]
// ----------------------------------------------------------------------------
// lease_lock_table
// per-bus table of lockable entries with owner session and lease countdown
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  command  | start, busy            | func, bus, address, session,
//           |                        | lease_seconds
//  result   | done (one-cycle pulse) | status, owner, released_count
//  config   | cfg_we                 | cfg_index, cfg_data
//
//  steps: activate, deactivate, lock, unlock and get owner read the entry,
//    then update it where the function calls for it; tick and release walk
//    addresses 1 to entries_per_bus on buses 0 to highest bus, one served entry
//    per cycle, through the single read-modify-write path through the entry store
//  reset: a clearing pass writes every entry to zero with busy high; config
//    writes are taken during it
//  stalls: the receiver cannot stall, done pulses for one cycle per item
//
module lease_lock_table
    import llt_pkg::*;
#(
    parameter int BUS_COUNT = DEF_BUS_COUNT,
    parameter int ENTRIES   = DEF_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command item
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [BUS_W-1:0]   bus,
    input  logic [ADDR_W-1:0]  address,
    input  logic [SESS_W-1:0]  session,
    input  logic [LEASE_W-1:0] lease_seconds,
    // result item
    output logic               done,
    output logic [1:0]         status,
    output logic [SESS_W-1:0]  owner,
    output logic [CNT_W-1:0]   released_count,
    // configuration writes
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [ADDR_W-1:0]  cfg_data
);

    localparam int REG_HIGHEST_BUS = 0;
    localparam int REG_ENTRIES     = 1;

    // walk limits clipped to the table size
    localparam logic [BUS_W-1:0]  BUS_CAP  =
        (BUS_COUNT - 1 > 3) ? BUS_W'(3) : BUS_W'(BUS_COUNT - 1);
    localparam logic [ADDR_W-1:0] ADDR_CAP =
        (ENTRIES - 1 > 255) ? ADDR_W'(255) : ADDR_W'(ENTRIES - 1);

    logic [BUS_W-1:0]  highest_bus_reg;
    logic [ADDR_W-1:0] entries_per_bus_reg;

    cmd_t    cmd;
    limit_t  lim;
    status_t status_w;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_bus_reg     <= '0;
            entries_per_bus_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (int'(cfg_index))
                REG_HIGHEST_BUS: highest_bus_reg     <= cfg_data[BUS_W-1:0];
                REG_ENTRIES:     entries_per_bus_reg <= cfg_data;
                default:         highest_bus_reg     <= highest_bus_reg;
            endcase
        end
    end

    // last bus and last address that a walk visits
    assign lim.bus_last  = (highest_bus_reg > BUS_CAP) ? BUS_CAP : highest_bus_reg;
    assign lim.addr_last = (entries_per_bus_reg > ADDR_CAP) ? ADDR_CAP
                                                            : entries_per_bus_reg;

    // command item, with address check against the configured range
    assign cmd.func    = func_t'(func);
    assign cmd.bus     = bus;
    assign cmd.address = address;
    assign cmd.session = session;
    assign cmd.lease   = lease_seconds;
    assign cmd.valid   = (bus <= lim.bus_last) && (address != '0)
                         && (address <= lim.addr_last);

    llt_seq #(
        .BUS_COUNT (BUS_COUNT),
        .ENTRIES   (ENTRIES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .cmd            (cmd),
        .lim            (lim),
        .busy           (busy),
        .done           (done),
        .status         (status_w),
        .owner          (owner),
        .released_count (released_count)
    );

    assign status = status_w;

endmodule

[rtl/llt_mem.sv]
// ----------------------------------------------------------------------------
// llt_mem
// entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module llt_mem
    import llt_pkg::*;
#(
    parameter int DEPTH = DEF_BUS_COUNT * DEF_ENTRIES,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem_array [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/llt_entry_unit.sv]
// ----------------------------------------------------------------------------
// llt_entry_unit
// update of one table entry for the current function, shared by all steps
// ----------------------------------------------------------------------------
module llt_entry_unit
    import llt_pkg::*;
(
    input  func_t              func,
    input  logic               valid,
    input  entry_t             entry,
    input  logic [SESS_W-1:0]  session,
    input  logic [LEASE_W-1:0] lease,
    output unit_res_t          res
);

    logic active;
    logic may_take;

    assign active   = valid && entry.active;
    assign may_take = (entry.owner == session) || (entry.owner == '0);

    always_comb
    begin
        res        = '0;
        res.entry  = entry;
        res.status = ST_OK;
        unique case (func)
            FN_ACTIVATE:
            begin
                if (valid)
                begin
                    res.entry        = '0;
                    res.entry.active = 1'b1;
                    res.wr           = 1'b1;
                end
                else
                begin
                    res.status = ST_WRONG;
                end
            end
            FN_DEACTIVATE:
            begin
                if (active)
                begin
                    res.entry = '0;
                    res.wr    = 1'b1;
                end
                else
                begin
                    res.status = ST_NODATA;
                end
            end
            FN_LOCK, FN_UNLOCK:
            begin
                if (!active)
                begin
                    res.status = ST_WRONG;
                end
                else if (may_take)
                begin
                    res.wr = 1'b1;
                    if (func == FN_LOCK)
                    begin
                        res.entry.owner = session;
                        res.entry.lease = lease;
                    end
                    else
                    begin
                        res.entry.owner = '0;
                    end
                end
                else
                begin
                    res.status = ST_LOCKED;
                end
            end
            FN_GET_OWNER:
            begin
                if (active)
                begin
                    res.owner = entry.owner;
                end
                else
                begin
                    res.status = ST_WRONG;
                end
            end
            FN_TICK:
            begin
                if (entry.lease != '0)
                begin
                    res.wr          = 1'b1;
                    res.entry.lease = entry.lease - LEASE_W'(1);
                    // lease runs out on an entry in service
                    if ((entry.lease == LEASE_W'(1)) && entry.active)
                    begin
                        res.entry.owner = '0;
                        res.rel         = 1'b1;
                    end
                end
            end
            FN_RELEASE:
            begin
                if (entry.active && (entry.owner == session))
                begin
                    res.wr          = 1'b1;
                    res.entry.owner = '0;
                    res.rel         = 1'b1;
                end
            end
            default:
            begin
                res.status = ST_WRONG;
            end
        endcase
    end

endmodule

[rtl/llt_seq.sv]
// ----------------------------------------------------------------------------
// llt_seq
// sequencer: clearing pass, single entry access and table walk
// ----------------------------------------------------------------------------
module llt_seq
    import llt_pkg::*;
#(
    parameter int BUS_COUNT = DEF_BUS_COUNT,
    parameter int ENTRIES   = DEF_ENTRIES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cmd_t              cmd,
    input  limit_t            lim,
    output logic              busy,
    output logic              done,
    output status_t           status,
    output logic [SESS_W-1:0] owner,
    output logic [CNT_W-1:0]  released_count
);

    localparam int DEPTH  = BUS_COUNT * ENTRIES;
    localparam int SLOT_W = $clog2(DEPTH);

    function automatic logic [SLOT_W-1:0] slot_of(input logic [BUS_W-1:0] b,
                                                  input logic [ADDR_W-1:0] a);
        return SLOT_W'(int'(b) * ENTRIES + int'(a));
    endfunction

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    cmd_t               cmd_reg, cmd_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [BUS_W-1:0]   wbus_reg, wbus_next;
    logic [ADDR_W-1:0]  waddr_reg, waddr_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [SESS_W-1:0]  owner_reg, owner_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    logic [SLOT_W-1:0]  mem_raddr;
    entry_t             mem_rdata;
    unit_res_t          res;

    logic               accept;
    logic               is_walk;
    logic               walk_empty;
    logic               walk_last;
    logic [BUS_W-1:0]   nbus;
    logic [ADDR_W-1:0]  naddr;

    llt_mem #(
        .DEPTH (DEPTH),
        .AW    (SLOT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    llt_entry_unit u_unit (
        .func    (cmd_reg.func),
        .valid   (cmd_reg.valid),
        .entry   (mem_rdata),
        .session (cmd_reg.session),
        .lease   (cmd_reg.lease),
        .res     (res)
    );

    assign accept     = start && (state_reg == S_IDLE);
    assign is_walk    = (cmd.func == FN_TICK) || (cmd.func == FN_RELEASE);
    assign walk_empty = (lim.addr_last == '0);
    assign walk_last  = (wbus_reg == lim.bus_last) && (waddr_reg == lim.addr_last);
    assign nbus       = (waddr_reg == lim.addr_last) ? wbus_reg + BUS_W'(1) : wbus_reg;
    assign naddr      = (waddr_reg == lim.addr_last) ? ADDR_W'(1) : waddr_reg + ADDR_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == SLOT_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!is_walk)
                    begin
                        state_next = S_ACCESS;
                    end
                    else if (!walk_empty)
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_ACCESS:
            begin
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        cmd_next     = cmd_reg;
        slot_next    = slot_reg;
        wbus_next    = wbus_reg;
        waddr_next   = waddr_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        owner_next   = owner_reg;
        count_next   = count_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot_reg;
        mem_wdata    = res.entry;
        mem_raddr    = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd;
                    status_next = ST_OK;
                    owner_next  = '0;
                    count_next  = '0;
                    if (is_walk)
                    begin
                        cmd_next.valid = 1'b1;
                        wbus_next      = '0;
                        waddr_next     = ADDR_W'(1);
                        slot_next      = slot_of('0, ADDR_W'(1));
                        mem_raddr      = slot_of('0, ADDR_W'(1));
                        done_next      = walk_empty;
                    end
                    else
                    begin
                        slot_next = cmd.valid ? slot_of(cmd.bus, cmd.address) : '0;
                        mem_raddr = cmd.valid ? slot_of(cmd.bus, cmd.address) : '0;
                    end
                end
            end
            S_ACCESS:
            begin
                mem_we      = res.wr;
                done_next   = 1'b1;
                status_next = res.status;
                owner_next  = res.owner;
            end
            S_WALK:
            begin
                mem_we     = res.wr;
                count_next = count_reg + CNT_W'(res.rel);
                if (walk_last)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    wbus_next  = nbus;
                    waddr_next = naddr;
                    slot_next  = slot_of(nbus, naddr);
                    mem_raddr  = slot_of(nbus, naddr);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        wbus_reg   <= wbus_next;
        waddr_reg  <= waddr_next;
        status_reg <= status_next;
        owner_reg  <= owner_next;
        count_reg  <= count_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign owner          = owner_reg;
    assign released_count = count_reg;

endmodule
